### hw/rtl/crc32e_pkg.sv
`timescale 1ns / 1ps

package crc32e_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POLY = 2'd0;
  localparam cfg_idx_t CFG_SKIP = 2'd1;

  // Field widths and reset values.
  typedef logic [31:0] crc_word_t;
  typedef logic [7:0]  data_byte_t;
  typedef logic [3:0]  count_t;

  localparam crc_word_t POLY_RESET = 32'h5607_0368;
  localparam count_t    SKIP_RESET = 4'd4;
  localparam count_t    SEEN_MAX   = 4'd15;
  localparam int        TOP_SHIFT  = 24;

  // Fold one byte into the CRC, MSB first, eight shift and reduce steps.
  function automatic crc_word_t crc_fold_byte(input crc_word_t crc, input data_byte_t data,
                                              input crc_word_t poly);
    crc_word_t c;
    c = crc ^ (crc_word_t'(data) << TOP_SHIFT);
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = (c << 1) ^ poly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### hw/rtl/crc32_msb_first_byte_engine.sv
`timescale 1ns / 1ps

// CRC-32 byte engine, MSB first, non-reflected, zero initial value, no final XOR.
// Input channel: in_data_byte and in_last_byte, one word per cycle, taken when
// in_valid is high and in_stall is low. The first skip_count bytes of each
// message are left out of the CRC; every later byte is folded in.
// Result channel: out_crc_value, one word per message, posted once the last byte leaves the input register.
// It is taken when out_valid is high and out_stall is low.
// Configuration: cfg_index 0 writes the generator polynomial (reset 0x56070368),
// cfg_index 1 the skip count (reset 4); other indexes are ignored. cfg_ready is
// always high. Write only while no message is in flight.
// Path: an accepted word sits in the input register; once a last byte leaves it,
// its result is registered in the output register and out_valid rises.
// Throughput: one byte per cycle while in_stall stays low; the unrolled eight-bit fold sits between the
// input register and the CRC accumulator.
// Reset clears the accumulator, byte count and both valid flags and restores
// the register defaults. When the receiver stalls, the result holds in the
// output register; a last byte waits in the input register until it frees,
// and in_stall is high only in that case.
module crc32_msb_first_byte_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_crc_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  crc32e_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]           cfg_data
);
  import crc32e_pkg::*;

  crc_word_t  poly_r;
  count_t     skip_r;
  crc_word_t  crc_acc_r;
  crc_word_t  crc_acc_nxt;
  count_t     bytes_seen_r;
  count_t     bytes_seen_nxt;
  logic       s1_valid_r;
  data_byte_t s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  crc_word_t  out_crc_r;
  crc_word_t  crc_folded;
  logic       out_free;
  logic       s1_advance;
  logic       in_take;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
      skip_r <= SKIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POLY: poly_r <= cfg_data;
        CFG_SKIP: skip_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Handshake between the input register and the output register.
  assign out_free   = !out_valid_r || !out_stall;
  assign s1_advance = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Fold the byte once past the skip region, count bytes up to saturation, and clear both on a last byte.
  always_comb begin
    if (bytes_seen_r >= skip_r) begin
      crc_folded = crc_fold_byte(crc_acc_r, s1_byte_r, poly_r);
    end else begin
      crc_folded = crc_acc_r;
    end
    crc_acc_nxt    = crc_acc_r;
    bytes_seen_nxt = bytes_seen_r;
    if (s1_advance) begin
      if (s1_last_r) begin
        crc_acc_nxt    = '0;
        bytes_seen_nxt = '0;
      end else begin
        crc_acc_nxt = crc_folded;
        if (bytes_seen_r < SEEN_MAX) begin
          bytes_seen_nxt = bytes_seen_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_acc_r    <= '0;
      bytes_seen_r <= '0;
    end else begin
      crc_acc_r    <= crc_acc_nxt;
      bytes_seen_r <= bytes_seen_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last_r) begin
      out_crc_r <= crc_folded;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  // A stall on the input side only happens with a last byte held behind a full output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // Delivering a last byte posts a result and clears the message state.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_last_r) |=> (out_valid_r && crc_acc_r == '0 && bytes_seen_r == '0))
    else $error("last byte did not post a result and clear state");

  // A byte inside the skip region leaves the accumulator unchanged.
  a_skip_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && !s1_last_r && bytes_seen_r < skip_r) |=> $stable(crc_acc_r))
    else $error("skipped byte changed the CRC");

  // With no word delivered the accumulator and byte count hold.
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_advance |=> ($stable(crc_acc_r) && $stable(bytes_seen_r)))
    else $error("message state changed with no byte delivered");

endmodule

### tb/sv/crc32_msb_first_byte_engine_tb.sv
`timescale 1ns / 1ps

module crc32_msb_first_byte_engine_tb;
  import crc32e_pkg::*;

  // Indexes that decode to no register.
  localparam cfg_idx_t CFG_UNUSED_A = 2'd2;
  localparam cfg_idx_t CFG_UNUSED_B = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 4;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  data_byte_t in_data_byte = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  crc_word_t  out_crc_value;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = CFG_POLY;
  crc_word_t  cfg_data = '0;

  // Golden copy of the registers and the running CRC.
  crc_word_t  model_poly = POLY_RESET;
  count_t     model_skip = SKIP_RESET;
  crc_word_t  model_crc = '0;
  count_t     model_seen = '0;

  crc_word_t  crc_words_due[$];
  crc_word_t  crc_want;
  int         error_count = 0;
  int         bytes_sent = 0;
  int         messages_sent = 0;
  int         crcs_checked = 0;
  int         cfg_writes = 0;
  int         cycle_count = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;

  crc32_msb_first_byte_engine u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_crc_value(out_crc_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bitwise MSB-first division step: each data bit joins the feedback term.
  function automatic crc_word_t fold_crc_byte(input crc_word_t acc, input data_byte_t d,
                                              input crc_word_t poly);
    crc_word_t r;
    logic      fb;
    r = acc;
    for (int b = 7; b >= 0; b--) begin
      fb = r[31] ^ d[b];
      r = {r[30:0], 1'b0};
      if (fb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  // Advances the golden state by one byte; returns 1 when a CRC word is due.
  function automatic logic predict_crc_step(input data_byte_t d, input logic last,
                                            output crc_word_t word);
    word = '0;
    if (model_seen >= model_skip) begin
      model_crc = fold_crc_byte(model_crc, d, model_poly);
    end
    if (model_seen != SEEN_MAX) begin
      model_seen = model_seen + 1'b1;
    end
    if (!last) begin
      return 1'b0;
    end
    word = model_crc;
    model_crc = '0;
    model_seen = '0;
    return 1'b1;
  endfunction

  // Sends one word and records the CRC it completes, if any. Valid is left
  // high so back-to-back words need no second assignment in one step.
  task automatic send_byte(input data_byte_t d, input logic last);
    crc_word_t word;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    bytes_sent++;
    if (predict_crc_step(d, last, word)) begin
      crc_words_due.push_back(word);
      messages_sent++;
    end
  endtask

  // Registers change only once the engine has drained every message.
  task automatic cfg_write(input cfg_idx_t idx, input crc_word_t value);
    in_valid <= 1'b0;
    while (crc_words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (idx)
      CFG_POLY: model_poly = value;
      CFG_SKIP: model_skip = value[3:0];
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(data_byte_t'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Picks a new polynomial and skip count, leaning on the extremes, and sometimes writes an unused index.
  task automatic randomize_registers();
    crc_word_t poly;
    count_t    skip;
    case ($urandom_range(0, 4))
      0: poly = '0;
      1: poly = '1;
      2: poly = POLY_RESET;
      default: poly = $urandom();
    endcase
    case ($urandom_range(0, 3))
      0: skip = '0;
      1: skip = SEEN_MAX;
      default: skip = count_t'($urandom_range(0, 15));
    endcase
    cfg_write(CFG_POLY, poly);
    // Upper data bits are junk; only the low nibble should stick.
    cfg_write(CFG_SKIP, {28'($urandom()), skip});
    if ($urandom_range(0, 3) == 0) begin
      cfg_write($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom());
    end
  endtask

  // Reset values: a last byte inside the skip region, a message exactly as
  // long as the skip count, and one that folds extreme byte values.
  task automatic test_default_registers();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Zero and all-ones polynomials, skip of zero through a masked write, and
  // writes to unused indexes that must leave the registers alone.
  task automatic test_register_extremes();
    cfg_write(CFG_POLY, 32'h0000_0000);
    cfg_write(CFG_SKIP, 32'hFFFF_FFF0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    cfg_write(CFG_POLY, 32'hFFFF_FFFF);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
    cfg_write(CFG_UNUSED_A, 32'h1234_5678);
    cfg_write(CFG_UNUSED_B, 32'h0000_0000);
    send_byte(8'hFF, 1'b1);
    cfg_write(CFG_POLY, POLY_RESET);
    cfg_write(CFG_SKIP, 32'h0000_0001);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Messages past the point where the byte count saturates.
  task automatic test_long_messages();
    cfg_write(CFG_SKIP, crc_word_t'(SEEN_MAX));
    for (int m = 0; m < 3; m++) begin
      send_random_message($urandom_range(15, 22));
    end
    cfg_write(CFG_SKIP, 32'h0000_0000);
    for (int m = 0; m < 2; m++) begin
      send_random_message($urandom_range(17, 30));
    end
  endtask

  // Mostly short messages with random content and occasional new settings.
  task automatic test_random_messages(input int item_goal);
    int sent_here;
    int len;
    sent_here = 0;
    while (sent_here < item_goal) begin
      if ($urandom_range(0, 9) == 0) begin
        randomize_registers();
      end
      case ($urandom_range(0, 9))
        7, 8: len = $urandom_range(9, 16);
        9: len = $urandom_range(17, 24);
        default: len = $urandom_range(1, 8);
      endcase
      send_random_message(len);
      sent_here += len;
    end
  endtask

  // Receiver stall and result check against the oldest pending CRC word.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (crc_words_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected CRC word, expected none, actual %08h", $time, out_crc_value);
      end else begin
        crc_want = crc_words_due.pop_front();
        crcs_checked++;
        if (out_crc_value !== crc_want) begin
          error_count++;
          $display("%0t: crc_value mismatch, expected %08h, actual %08h", $time, crc_want,
                   out_crc_value);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d CRC words still pending", $time, crc_words_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 10;
    rx_stall_pct = 57;
    test_default_registers();
    test_register_extremes();
    test_long_messages();
    test_random_messages(225);

    tx_idle_pct = 57;
    rx_stall_pct = 10;
    test_random_messages(225);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    test_random_messages(225);

    in_valid <= 1'b0;
    while (crc_words_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d messages with %0d register writes.", bytes_sent,
             messages_sent, cfg_writes);
    $display("Checked %0d CRC words under three idle patterns, %0d errors.", crcs_checked,
             error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
